[src/cartridge_bank_mapper_scanline_irq_unit_defines.svh]
// Assertion macros shared by the cartridge mapper RTL.
// Included by every module that carries concurrent assertions; needs nothing else.
`ifndef CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CBM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CBM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbm assertion failed");

`endif

[src/cbm_pkg.sv]
// Shared types, address constants and helper functions of the cartridge mapper.
// Used by cbm_regs and the top level; depends on nothing.
package cbm_pkg;

   localparam int WORK_RAM_BYTES = 8192;
   localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);

   localparam logic [8:0] VISIBLE_LAST_LINE = 9'd239;

   localparam logic [15:0] PRG_BANK_BASE = 16'h8000;
   localparam logic [15:0] CHR_BANK_BASE = 16'h9000;
   localparam logic [15:0] IRQ_ACK_ADDR  = 16'hC002;
   localparam logic [15:0] IRQ_EN_ADDR   = 16'hC003;
   localparam logic [15:0] IRQ_LOAD_ADDR = 16'hC005;
   localparam logic [15:0] MIRROR_ADDR   = 16'hD001;
   localparam logic [2:0]  WRAM_WINDOW   = 3'b011;    // top bits of 0x6000-0x7FFF
   localparam logic [1:0]  FIXED_SLOT    = 2'd3;      // 0xE000-0xFFFF

   localparam logic [7:0] PRG_MASK_RESET = 8'd31;
   localparam logic [7:0] CHR_MASK_RESET = 8'd255;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic {
      CSR_PRG_MASK = 1'b0,
      CSR_CHR_MASK = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CPU_WRITE = 2'd0,
      KIND_CPU_READ  = 2'd1,
      KIND_TICK      = 2'd2,
      KIND_PPU_FETCH = 2'd3
   } kind_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [WRAM_AW-1:0] addr;
      logic [7:0]         wdata;
   } cbm_ram_req_type;

   typedef struct packed {
      logic        read_valid;
      logic [20:0] prg_rom_address;
      logic        prg_valid;
      logic [17:0] chr_rom_address;
      logic [1:0]  mirror_mode;
      logic        irq_line;
   } cbm_result_type;

   // Offset within the 8K window folded onto the work RAM size. The quotient
   // never exceeds seven, so three restoring subtract steps are enough.
   function automatic logic [WRAM_AW-1:0] wram_index(input logic [12:0] offset);
      logic [15:0] rem;
      rem = {3'b000, offset};
      if (rem >= 16'(4 * WORK_RAM_BYTES)) rem = rem - 16'(4 * WORK_RAM_BYTES);
      if (rem >= 16'(2 * WORK_RAM_BYTES)) rem = rem - 16'(2 * WORK_RAM_BYTES);
      if (rem >= 16'(WORK_RAM_BYTES))     rem = rem - 16'(WORK_RAM_BYTES);
      return rem[WRAM_AW-1:0];
   endfunction

endpackage

[src/cbm_wram.sv]
// Generic single-port synchronous RAM with a registered read port.
// Stands alone; the read data holds until the next read enable.
module cbm_wram #(
   parameter int DEPTH  = 8192,
   parameter int DATA_W = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] ram_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= ram_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/cbm_regs.sv]
// Mapper register file: bank registers, mirroring, scanline IRQ counter and CSRs.
// Decodes each accepted transaction and forms the work RAM request and result fields.
// Depends on cbm_pkg and the assertion macro header.
`include "cartridge_bank_mapper_scanline_irq_unit_defines.svh"

module cbm_regs
   import cbm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          req_kind,
   input  logic [15:0]         req_cpu_addr,
   input  logic [7:0]          req_bus_data,
   input  logic [12:0]         req_ppu_addr,
   input  logic [8:0]          req_line_number,
   input  logic                req_display_on,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output cbm_ram_req_type     ram_req,
   output cbm_result_type      result
);

   logic [7:0] prg_mask_ff, prg_mask_in;
   logic [7:0] chr_mask_ff, chr_mask_in;
   logic [7:0] prg_bank_ff [3];
   logic [7:0] prg_bank_in [3];
   logic [7:0] chr_bank_ff [8];
   logic [7:0] chr_bank_in [8];
   logic [7:0] mirror_ff, mirror_in;
   logic [7:0] irq_counter_ff, irq_counter_in;
   logic       irq_enable_ff, irq_enable_in;
   logic       irq_pending_ff, irq_pending_in;

   kind_type      kind;
   csr_index_type csr_index;
   logic          csr_write;
   logic          in_wram;
   logic [1:0]    prg_slot;
   logic [7:0]    prg_bank;
   logic [7:0]    chr_bank;
   logic [7:0]    counter_dec;

   assign kind      = kind_type'(req_kind);
   assign csr_index = csr_index_type'(csr_paddr[2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign in_wram   = (req_cpu_addr[15:13] == WRAM_WINDOW);

   always_comb begin
      unique case (csr_index)
         CSR_PRG_MASK: csr_prdata = {24'd0, prg_mask_ff};
         CSR_CHR_MASK: csr_prdata = {24'd0, chr_mask_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      prg_mask_in = prg_mask_ff;
      chr_mask_in = chr_mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PRG_MASK: prg_mask_in = csr_pwdata[7:0];
            CSR_CHR_MASK: chr_mask_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign counter_dec = irq_counter_ff - 8'd1;

   always_comb begin
      prg_bank_in    = prg_bank_ff;
      chr_bank_in    = chr_bank_ff;
      mirror_in      = mirror_ff;
      irq_counter_in = irq_counter_ff;
      irq_enable_in  = irq_enable_ff;
      irq_pending_in = irq_pending_ff;
      if (accept) begin
         unique case (kind)
            KIND_CPU_WRITE: begin
               if (!in_wram) begin
                  priority if (req_cpu_addr[15:2] == PRG_BANK_BASE[15:2]
                               && req_cpu_addr[1:0] != FIXED_SLOT) begin
                     prg_bank_in[req_cpu_addr[1:0]] = req_bus_data;
                  end else if (req_cpu_addr[15:3] == CHR_BANK_BASE[15:3]) begin
                     chr_bank_in[req_cpu_addr[2:0]] = req_bus_data;
                  end else if (req_cpu_addr == IRQ_ACK_ADDR) begin
                     irq_enable_in  = 1'b0;
                     irq_pending_in = 1'b0;
                  end else if (req_cpu_addr == IRQ_EN_ADDR) begin
                     irq_enable_in = 1'b1;
                  end else if (req_cpu_addr == IRQ_LOAD_ADDR) begin
                     irq_counter_in = req_bus_data;
                  end else if (req_cpu_addr == MIRROR_ADDR) begin
                     mirror_in = req_bus_data;
                  end else begin
                  end
               end
            end
            KIND_TICK: begin
               if (req_line_number <= VISIBLE_LAST_LINE && req_display_on
                   && irq_enable_ff) begin
                  irq_counter_in = counter_dec;
                  // Reaching zero raises the request; starting from zero just wraps.
                  if (counter_dec == 8'd0) begin
                     irq_pending_in = 1'b1;
                     irq_enable_in  = 1'b0;
                  end
               end
            end
            KIND_CPU_READ, KIND_PPU_FETCH: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_mask_ff    <= PRG_MASK_RESET;
         chr_mask_ff    <= CHR_MASK_RESET;
         prg_bank_ff    <= '{default: 8'd0};
         chr_bank_ff    <= '{default: 8'd0};
         mirror_ff      <= 8'd0;
         irq_counter_ff <= 8'd0;
         irq_enable_ff  <= 1'b0;
         irq_pending_ff <= 1'b0;
      end else begin
         prg_mask_ff    <= prg_mask_in;
         chr_mask_ff    <= chr_mask_in;
         prg_bank_ff    <= prg_bank_in;
         chr_bank_ff    <= chr_bank_in;
         mirror_ff      <= mirror_in;
         irq_counter_ff <= irq_counter_in;
         irq_enable_ff  <= irq_enable_in;
         irq_pending_ff <= irq_pending_in;
      end
   end

   // Bank lookups for the result fields.
   assign prg_slot = req_cpu_addr[14:13];
   assign prg_bank = (prg_slot == FIXED_SLOT) ? prg_mask_ff
                                              : (prg_bank_ff[prg_slot] & prg_mask_ff);
   assign chr_bank = chr_bank_ff[req_ppu_addr[12:10]] & chr_mask_ff;

   always_comb begin
      result                 = '0;
      result.mirror_mode     = {mirror_in[1], ~mirror_in[0]};
      result.irq_line        = irq_pending_in;
      ram_req.we             = 1'b0;
      ram_req.re             = 1'b0;
      ram_req.addr           = wram_index(req_cpu_addr[12:0]);
      ram_req.wdata          = req_bus_data;
      unique case (kind)
         KIND_CPU_WRITE: begin
            ram_req.we = accept && in_wram;
         end
         KIND_CPU_READ: begin
            if (in_wram) begin
               ram_req.re        = accept;
               result.read_valid = 1'b1;
            end else if (req_cpu_addr[15]) begin
               result.prg_rom_address = {prg_bank, req_cpu_addr[12:0]};
               result.prg_valid       = 1'b1;
            end
         end
         KIND_PPU_FETCH: begin
            result.chr_rom_address = {chr_bank, req_ppu_addr[9:0]};
         end
         KIND_TICK: ;
         default: ;
      endcase
   end

   `CBM_ASSERT_IMPLY(a_irq_rise_from_enable, clock, reset, $rose(irq_pending_ff),
                     $past(irq_enable_ff) && !irq_enable_ff)
   `CBM_ASSERT_IMPLY(a_irq_rise_at_zero, clock, reset, $rose(irq_pending_ff),
                     irq_counter_ff == 8'd0)
   `CBM_ASSERT_NEXT(a_counter_idle_stable, clock, reset, !accept,
                    $stable(irq_counter_ff) && $stable(irq_pending_ff))

endmodule

[src/cartridge_bank_mapper_scanline_irq_unit.sv]
// Cartridge bank mapper with scanline IRQ. One transaction is accepted per clock
// while req_ready is high: the first stage issues the work RAM access and
// updates the bank and IRQ registers, and when it advances the result register
// takes the result with the RAM read data. The single-port 8K work RAM allows
// one access per cycle; a write followed by a read of the same byte in the next
// cycle returns the new value. The first stage can take one more transaction
// while a result waits. The program and pattern bank masks are written through
// the CSR port at byte addresses 0 and 4; the user must write them only while
// the block is idle, which it does not enforce. Depends on cbm_pkg, cbm_regs,
// cbm_wram and the assertion macro header.
`include "cartridge_bank_mapper_scanline_irq_unit_defines.svh"

module cartridge_bank_mapper_scanline_irq_unit
   import cbm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [15:0]       req_cpu_addr,
   input  logic [7:0]        req_bus_data,
   input  logic [12:0]       req_ppu_addr,
   input  logic [8:0]        req_line_number,
   input  logic              req_display_on,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_read_valid,
   output logic [20:0]       rsp_prg_rom_address,
   output logic              rsp_prg_valid,
   output logic [17:0]       rsp_chr_rom_address,
   output logic [1:0]        rsp_mirror_mode,
   output logic              rsp_irq_line,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cbm_ram_req_type ram_req;
   cbm_result_type  result;
   logic [7:0]      ram_rdata;

   logic           accept;
   logic           advance;
   logic           s1_valid_ff, s1_valid_in;
   cbm_result_type s1_result_ff;
   logic           out_valid_ff, out_valid_in;
   cbm_result_type out_result_ff;
   logic [7:0]     out_rdata_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   cbm_regs u_regs (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_kind        (req_kind),
      .req_cpu_addr    (req_cpu_addr),
      .req_bus_data    (req_bus_data),
      .req_ppu_addr    (req_ppu_addr),
      .req_line_number (req_line_number),
      .req_display_on  (req_display_on),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .ram_req         (ram_req),
      .result          (result)
   );

   // The RAM output only changes on a read issued at accept, so it still belongs
   // to the transaction in the first stage while that stage is stalled.
   cbm_wram #(
      .DEPTH  (WORK_RAM_BYTES),
      .DATA_W (8)
   ) u_wram (
      .clock (clock),
      .we    (ram_req.we),
      .re    (ram_req.re),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= result;
      end
      if (advance && s1_valid_ff) begin
         out_result_ff <= s1_result_ff;
         out_rdata_ff  <= s1_result_ff.read_valid ? ram_rdata : 8'd0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = out_rdata_ff;
   assign rsp_read_valid      = out_result_ff.read_valid;
   assign rsp_prg_rom_address = out_result_ff.prg_rom_address;
   assign rsp_prg_valid       = out_result_ff.prg_valid;
   assign rsp_chr_rom_address = out_result_ff.chr_rom_address;
   assign rsp_mirror_mode     = out_result_ff.mirror_mode;
   assign rsp_irq_line        = out_result_ff.irq_line;
   assign csr_pready          = 1'b1;

   `CBM_ASSERT_IMPLY(a_full_pipe_blocks_input, clock, reset,
                     s1_valid_ff && out_valid_ff && !rsp_ready, !req_ready)
   `CBM_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_valid && req_ready,
                    s1_valid_ff)
   `CBM_ASSERT_IMPLY(a_rdata_zero_unless_ram, clock, reset,
                     rsp_valid && !rsp_read_valid, rsp_read_data == 8'd0)

endmodule

[verif/tb_cartridge_bank_mapper_scanline_irq_unit.sv]
// Self-checking testbench for the cartridge bank mapper with scanline IRQ.
// Drives bus transactions and mask writes, takes each expectation from a local
// mapper model or a typed row, checks it field by field; needs cbm_pkg and RTL.
`timescale 1ns / 100ps

module tb_cartridge_bank_mapper_scanline_irq_unit;
   import cbm_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 205;
   localparam int HOLDOFF_LEN   = 80;
   localparam int PRINT_LIMIT   = 40;
   localparam int RAM_ALIASES   = 8192 / WORK_RAM_BYTES;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] cpu_addr;
      logic [7:0]  bus_data;
      logic [12:0] ppu_addr;
      logic [8:0]  line_number;
      logic        display_on;
   } bus_access_type;

   typedef struct {
      logic [7:0]  read_data;
      logic        read_valid;
      logic [20:0] prg_rom_address;
      logic        prg_valid;
      logic [17:0] chr_rom_address;
      logic [1:0]  mirror_mode;
      logic        irq_line;
   } mapper_result_type;

   typedef struct {
      bus_access_type    access;
      bit                typed;
      mapper_result_type result;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_kind = 2'd0;
   logic [15:0]       req_cpu_addr = 16'd0;
   logic [7:0]        req_bus_data = 8'd0;
   logic [12:0]       req_ppu_addr = 13'd0;
   logic [8:0]        req_line_number = 9'd0;
   logic              req_display_on = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_read_data;
   logic              rsp_read_valid;
   logic [20:0]       rsp_prg_rom_address;
   logic              rsp_prg_valid;
   logic [17:0]       rsp_chr_rom_address;
   logic [1:0]        rsp_mirror_mode;
   logic              rsp_irq_line;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Typed expectation travelling with the transaction on the request port.
   bit                req_typed = 1'b0;
   mapper_result_type req_typed_result;

   // Local copy of the mapper state.
   logic [7:0] prg_mask;
   logic [7:0] chr_mask;
   logic [7:0] prg_banks [3];
   logic [7:0] chr_banks [8];
   logic [7:0] mirror_reg;
   logic [7:0] irq_counter;
   logic       irq_enable;
   logic       irq_pending;
   logic [7:0] wram_model [WORK_RAM_BYTES];

   // Stimulus-side record of which work RAM bytes hold a known value.
   bit          ram_written [WORK_RAM_BYTES];
   logic [12:0] written_offsets [$];

   mapper_result_type expected_results [$];
   mapper_result_type unchecked;
   directed_row_type  directed_rows [$];
   idle_mode_type     idle_mode = IDLE_NONE;
   int                mismatch_count = 0;
   int                items_sent = 0;
   int                cycle_count = 0;
   int                holdoff_requests = 0;
   int                holdoff_seen = 0;
   int                holdoff_left = 0;

   cartridge_bank_mapper_scanline_irq_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_cpu_addr        (req_cpu_addr),
      .req_bus_data        (req_bus_data),
      .req_ppu_addr        (req_ppu_addr),
      .req_line_number     (req_line_number),
      .req_display_on      (req_display_on),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_prg_rom_address (rsp_prg_rom_address),
      .rsp_prg_valid       (rsp_prg_valid),
      .rsp_chr_rom_address (rsp_chr_rom_address),
      .rsp_mirror_mode     (rsp_mirror_mode),
      .rsp_irq_line        (rsp_irq_line),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   function automatic bit in_wram_window(input logic [15:0] addr);
      return addr[15:13] == WRAM_WINDOW;
   endfunction

   // Applies one transaction to the local mapper state and returns its result.
   function automatic mapper_result_type map_bus_access(input bus_access_type a);
      mapper_result_type r;
      logic [7:0]        bank;
      logic [1:0]        slot;
      int                offset;
      r = '{default: '0};
      offset = int'(a.cpu_addr[12:0]) % WORK_RAM_BYTES;
      case (a.kind)
         KIND_CPU_WRITE: begin
            if (in_wram_window(a.cpu_addr))
               wram_model[offset] = a.bus_data;
            else if (a.cpu_addr >= PRG_BANK_BASE && a.cpu_addr <= PRG_BANK_BASE + 16'd2)
               prg_banks[a.cpu_addr[1:0]] = a.bus_data;
            else if (a.cpu_addr >= CHR_BANK_BASE && a.cpu_addr <= CHR_BANK_BASE + 16'd7)
               chr_banks[a.cpu_addr[2:0]] = a.bus_data;
            else if (a.cpu_addr == IRQ_ACK_ADDR) begin
               irq_enable = 1'b0;
               irq_pending = 1'b0;
            end else if (a.cpu_addr == IRQ_EN_ADDR)
               irq_enable = 1'b1;
            else if (a.cpu_addr == IRQ_LOAD_ADDR)
               irq_counter = a.bus_data;
            else if (a.cpu_addr == MIRROR_ADDR)
               mirror_reg = a.bus_data;
         end
         KIND_CPU_READ: begin
            if (in_wram_window(a.cpu_addr)) begin
               r.read_data = wram_model[offset];
               r.read_valid = 1'b1;
            end else if (a.cpu_addr[15]) begin
               slot = a.cpu_addr[14:13];
               bank = (slot == FIXED_SLOT) ? prg_mask : (prg_banks[slot] & prg_mask);
               r.prg_rom_address = {bank, a.cpu_addr[12:0]};
               r.prg_valid = 1'b1;
            end
         end
         KIND_TICK: begin
            if (a.line_number <= VISIBLE_LAST_LINE && a.display_on && irq_enable) begin
               irq_counter = irq_counter - 8'd1;
               if (irq_counter == 8'd0) begin
                  irq_pending = 1'b1;
                  irq_enable = 1'b0;
               end
            end
         end
         default: begin
            bank = chr_banks[a.ppu_addr[12:10]] & chr_mask;
            r.chr_rom_address = {bank, a.ppu_addr[9:0]};
         end
      endcase
      r.mirror_mode = mirror_reg[1:0] ^ 2'b01;
      r.irq_line = irq_pending;
      return r;
   endfunction

   // Predicts accepted requests and checks returned results in order.
   always @(posedge clock) begin
      bus_access_type    a;
      mapper_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            a.kind = kind_type'(req_kind);
            a.cpu_addr = req_cpu_addr;
            a.bus_data = req_bus_data;
            a.ppu_addr = req_ppu_addr;
            a.line_number = req_line_number;
            a.display_on = req_display_on;
            want = map_bus_access(a);
            if (req_typed)
               want = req_typed_result;
            expected_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_read_valid !== want.read_valid)
                  report_mismatch("read_valid", rsp_read_valid, want.read_valid);
               if (rsp_prg_rom_address !== want.prg_rom_address)
                  report_mismatch("prg_rom_address", rsp_prg_rom_address,
                                  want.prg_rom_address);
               if (rsp_prg_valid !== want.prg_valid)
                  report_mismatch("prg_valid", rsp_prg_valid, want.prg_valid);
               if (rsp_chr_rom_address !== want.chr_rom_address)
                  report_mismatch("chr_rom_address", rsp_chr_rom_address,
                                  want.chr_rom_address);
               if (rsp_mirror_mode !== want.mirror_mode)
                  report_mismatch("mirror_mode", rsp_mirror_mode, want.mirror_mode);
               if (rsp_irq_line !== want.irq_line)
                  report_mismatch("irq_line", rsp_irq_line, want.irq_line);
            end
         end
      end
   end

   // Result side: random stalls per phase, plus long hold-offs on request.
   always @(posedge clock) begin
      int stall_pct;
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 47 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready <= 1'b0;
      end else if (holdoff_seen != holdoff_requests) begin
         holdoff_seen <= holdoff_requests;
         holdoff_left <= HOLDOFF_LEN;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic bus_access_type acc(input kind_type k, input logic [15:0] addr,
                                          input logic [7:0] data, input logic [12:0] paddr,
                                          input logic [8:0] line, input logic disp);
      bus_access_type a;
      a.kind = k;
      a.cpu_addr = addr;
      a.bus_data = data;
      a.ppu_addr = paddr;
      a.line_number = line;
      a.display_on = disp;
      return a;
   endfunction

   function automatic mapper_result_type res(input logic [7:0] rd, input logic rv,
                                             input logic [20:0] prg, input logic pv,
                                             input logic [17:0] chr, input logic [1:0] mm,
                                             input logic irq);
      mapper_result_type r;
      r.read_data = rd;
      r.read_valid = rv;
      r.prg_rom_address = prg;
      r.prg_valid = pv;
      r.chr_rom_address = chr;
      r.mirror_mode = mm;
      r.irq_line = irq;
      return r;
   endfunction

   task automatic add_row(input bus_access_type a, input bit typed,
                          input mapper_result_type r);
      directed_row_type row;
      row.access = a;
      row.typed = typed;
      row.result = r;
      directed_rows.push_back(row);
   endtask

   function automatic logic [15:0] written_wram_addr();
      logic [12:0] offset;
      offset = written_offsets[$urandom_range(written_offsets.size() - 1)];
      offset = 13'(offset + WORK_RAM_BYTES * $urandom_range(RAM_ALIASES - 1));
      return {WRAM_WINDOW, offset};
   endfunction

   // Mostly legal register, work RAM and ROM traffic, fetches and ticks, some noise.
   function automatic bus_access_type random_access();
      bus_access_type a;
      int             pick;
      a = acc(KIND_PPU_FETCH, 16'($urandom), 8'($urandom), 13'($urandom),
              9'($urandom_range(261)), 1'($urandom));
      pick = $urandom_range(99);
      if (pick < 30) begin
         a.kind = KIND_CPU_WRITE;
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               case ($urandom_range(7))
                  0: a.cpu_addr = PRG_BANK_BASE + 16'($urandom_range(2));
                  1: a.cpu_addr = CHR_BANK_BASE + 16'($urandom_range(7));
                  2: a.cpu_addr = IRQ_ACK_ADDR;
                  3: a.cpu_addr = IRQ_EN_ADDR;
                  4: a.cpu_addr = IRQ_LOAD_ADDR;
                  5: a.cpu_addr = MIRROR_ADDR;
                  // Near misses of the register decode; the default range also hits real registers.
                  6: a.cpu_addr = PRG_BANK_BASE + 16'd3 + 16'($urandom_range(4));
                  default: a.cpu_addr = IRQ_ACK_ADDR - 16'd2 + 16'($urandom_range(4)) +
                                        16'($urandom_range(1)) * 16'h1000;
               endcase
            end
            5, 6, 7: a.cpu_addr = {WRAM_WINDOW, 13'($urandom)};
            default: ;
         endcase
      end else if (pick < 62) begin
         a.kind = KIND_CPU_READ;
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               if (written_offsets.size() != 0)
                  a.cpu_addr = written_wram_addr();
               else
                  a.cpu_addr = {1'b1, 15'($urandom)};
            end
            4, 5, 6, 7: a.cpu_addr = {1'b1, 15'($urandom)};
            default: ;
         endcase
         // Never read a work RAM byte that holds no known value.
         if (in_wram_window(a.cpu_addr) &&
             !ram_written[int'(a.cpu_addr[12:0]) % WORK_RAM_BYTES])
            a.kind = KIND_CPU_WRITE;
      end else if (pick >= 80) begin
         a.kind = KIND_TICK;
         if ($urandom_range(9) < 8)
            a.line_number = 9'($urandom_range(239));
         a.display_on = ($urandom_range(9) != 0);
      end
      return a;
   endfunction

   task automatic send(input bus_access_type a, input bit typed,
                       input mapper_result_type r);
      int idle_pct;
      int offset;
      idle_pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= a.kind;
      req_cpu_addr <= a.cpu_addr;
      req_bus_data <= a.bus_data;
      req_ppu_addr <= a.ppu_addr;
      req_line_number <= a.line_number;
      req_display_on <= a.display_on;
      req_typed <= typed;
      req_typed_result <= r;
      if (a.kind == KIND_CPU_WRITE && in_wram_window(a.cpu_addr)) begin
         offset = int'(a.cpu_addr[12:0]) % WORK_RAM_BYTES;
         if (!ram_written[offset]) begin
            ram_written[offset] = 1'b1;
            written_offsets.push_back(13'(offset));
         end
      end
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Load the counter, enable it and tick it down towards zero, with traffic mixed in.
   task automatic send_irq_sequence();
      int count;
      int i;
      count = $urandom_range(1, 6);
      send(acc(KIND_CPU_WRITE, IRQ_LOAD_ADDR, 8'(count), 13'($urandom), 9'($urandom), 1'b0),
           1'b0, unchecked);
      send(acc(KIND_CPU_WRITE, IRQ_EN_ADDR, 8'($urandom), 13'($urandom), 9'($urandom), 1'b1),
           1'b0, unchecked);
      for (i = 0; i < count + 2; i++) begin
         if ($urandom_range(3) == 0)
            send(random_access(), 1'b0, unchecked);
         else
            send(acc(KIND_TICK, 16'($urandom), 8'($urandom), 13'($urandom),
                     9'($urandom_range(239)), 1'b1), 1'b0, unchecked);
      end
      if ($urandom_range(4) != 0)
         send(acc(KIND_CPU_WRITE, IRQ_ACK_ADDR, 8'($urandom), 13'($urandom),
                  9'($urandom), 1'($urandom)), 1'b0, unchecked);
   endtask

   task automatic send_random_traffic(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 8)
            send_irq_sequence();
         else
            send(random_access(), 1'b0, unchecked);
      end
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(input csr_index_type idx, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_PRG_MASK)
         prg_mask = value;
      else
         chr_mask = value;
      // Read the register back.
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DW'(value))
         report_mismatch("mask readback", csr_prdata, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [7:0] prg_settings [7];
      logic [7:0] chr_settings [7];
      int         p;
      prg_settings = '{8'd31, 8'd0, 8'd255, 8'd7, 8'd255, 8'd63, 8'd0};
      chr_settings = '{8'd255, 8'd0, 8'd255, 8'd63, 8'd0, 8'd15, 8'd0};
      unchecked = '{default: '0};
      prg_mask = PRG_MASK_RESET;
      chr_mask = CHR_MASK_RESET;
      foreach (prg_banks[i]) prg_banks[i] = 8'd0;
      foreach (chr_banks[i]) chr_banks[i] = 8'd0;
      mirror_reg = 8'd0;
      irq_counter = 8'd0;
      irq_enable = 1'b0;
      irq_pending = 1'b0;

      // Reset state first, then extremes, bank loads, mirroring and the IRQ cases.
      add_row(acc(KIND_CPU_READ, 16'h8000, 8'h00, 13'h0000, 9'd0, 1'b0), 1'b1,
              res(8'h00, 1'b0, 21'h000000, 1'b1, 18'h00000, 2'd1, 1'b0));
      add_row(acc(KIND_CPU_READ, 16'hFFFF, 8'hFF, 13'h1FFF, 9'd261, 1'b1), 1'b1,
              res(8'h00, 1'b0, 21'h03FFFF, 1'b1, 18'h00000, 2'd1, 1'b0));
      add_row(acc(KIND_CPU_READ, 16'h0000, 8'h00, 13'h0000, 9'd0, 1'b0), 1'b1,
              res(8'h00, 1'b0, 21'h000000, 1'b0, 18'h00000, 2'd1, 1'b0));
      add_row(acc(KIND_CPU_READ, 16'h5FFF, 8'hFF, 13'h1FFF, 9'd261, 1'b1), 1'b1,
              res(8'h00, 1'b0, 21'h000000, 1'b0, 18'h00000, 2'd1, 1'b0));
      add_row(acc(KIND_PPU_FETCH, 16'h0000, 8'h00, 13'h1FFF, 9'd0, 1'b0), 1'b1,
              res(8'h00, 1'b0, 21'h000000, 1'b0, 18'h003FF, 2'd1, 1'b0));
      add_row(acc(KIND_CPU_WRITE, 16'h6000, 8'hFF, 13'h0000, 9'd0, 1'b0), 1'b1,
              res(8'h00, 1'b0, 21'h000000, 1'b0, 18'h00000, 2'd1, 1'b0));
      add_row(acc(KIND_CPU_WRITE, 16'h7FFF, 8'h00, 13'h0000, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_CPU_READ, 16'h6000, 8'h00, 13'h0000, 9'd0, 1'b0), 1'b1,
              res(8'hFF, 1'b1, 21'h000000, 1'b0, 18'h00000, 2'd1, 1'b0));
      add_row(acc(KIND_CPU_READ, 16'h7FFF, 8'h00, 13'h0000, 9'd0, 1'b0), 1'b1,
              res(8'h00, 1'b1, 21'h000000, 1'b0, 18'h00000, 2'd1, 1'b0));
      add_row(acc(KIND_CPU_WRITE, PRG_BANK_BASE, 8'hFF, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_CPU_WRITE, PRG_BANK_BASE + 16'd1, 8'hAA, 13'h0, 9'd0, 1'b0), 1'b0,
              unchecked);
      add_row(acc(KIND_CPU_WRITE, PRG_BANK_BASE + 16'd2, 8'h55, 13'h0, 9'd0, 1'b0), 1'b0,
              unchecked);
      add_row(acc(KIND_CPU_WRITE, CHR_BANK_BASE, 8'hFF, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_CPU_WRITE, CHR_BANK_BASE + 16'd7, 8'h80, 13'h0, 9'd0, 1'b0), 1'b0,
              unchecked);
      add_row(acc(KIND_CPU_WRITE, MIRROR_ADDR, 8'hFF, 13'h0000, 9'd0, 1'b0), 1'b1,
              res(8'h00, 1'b0, 21'h000000, 1'b0, 18'h00000, 2'd2, 1'b0));
      add_row(acc(KIND_CPU_READ, 16'h8000, 8'h00, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_CPU_READ, 16'hDFFF, 8'h00, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_PPU_FETCH, 16'h0000, 8'h00, 13'h0000, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_PPU_FETCH, 16'h0000, 8'h00, 13'h1C05, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_CPU_WRITE, PRG_BANK_BASE + 16'd3, 8'h12, 13'h0, 9'd0, 1'b0), 1'b0,
              unchecked);
      add_row(acc(KIND_CPU_WRITE, IRQ_LOAD_ADDR, 8'h01, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_CPU_WRITE, IRQ_EN_ADDR, 8'h00, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_TICK, 16'h0000, 8'h00, 13'h0, 9'd240, 1'b1), 1'b0, unchecked);
      add_row(acc(KIND_TICK, 16'h0000, 8'h00, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_TICK, 16'h0000, 8'h00, 13'h0, 9'd239, 1'b1), 1'b0, unchecked);
      add_row(acc(KIND_CPU_WRITE, IRQ_ACK_ADDR, 8'h00, 13'h0000, 9'd0, 1'b0), 1'b1,
              res(8'h00, 1'b0, 21'h000000, 1'b0, 18'h00000, 2'd2, 1'b0));
      // Enabled with the counter already at zero: it wraps and stays quiet.
      add_row(acc(KIND_CPU_WRITE, IRQ_EN_ADDR, 8'h00, 13'h0, 9'd0, 1'b0), 1'b0, unchecked);
      add_row(acc(KIND_TICK, 16'h0000, 8'h00, 13'h0, 9'd0, 1'b1), 1'b0, unchecked);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send(directed_rows[i].access, directed_rows[i].typed, directed_rows[i].result);

      for (p = 0; p < 7; p++) begin
         wait_until_idle();
         if (p == 6) begin
            prg_settings[p] = 8'($urandom);
            chr_settings[p] = 8'($urandom);
         end
         write_mask(CSR_PRG_MASK, prg_settings[p]);
         write_mask(CSR_CHR_MASK, chr_settings[p]);
         idle_mode = idle_mode_type'(p % 4);
         send_random_traffic(PHASE_ITEMS / 2);
         if (p % 2 == 0)
            holdoff_requests++;
         else
            wait_until_idle();
         send_random_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
      end

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[cartridge_bank_mapper_scanline_irq_unit.f]
+incdir+src
src/cbm_pkg.sv
src/cbm_wram.sv
src/cbm_regs.sv
src/cartridge_bank_mapper_scanline_irq_unit.sv
verif/tb_cartridge_bank_mapper_scanline_irq_unit.sv
